// ----- src/dlsq_pkg.sv -----
// ----------------------------------------------------------------------------
// dlsq_pkg
// Shared types and constants of the delta-list sleep queue.
// ----------------------------------------------------------------------------
package dlsq_pkg;

	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int MAX_RESULTS     = 16;
	localparam int TID_W           = 8;
	localparam int TICK_W          = 32;

	typedef enum logic {
		OPC_ADD  = 1'b0,
		OPC_TICK = 1'b1
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [TID_W-1:0]  thr;
		logic [TICK_W-1:0] ticks;
	} item_t;

	// list operations, one per cycle
	typedef enum logic [2:0] {
		SOP_NONE,
		SOP_POP,
		SOP_ROT,
		SOP_PUSH,
		SOP_DEC0
	} slot_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_REL,
		ST_EMIT
	} back_state_t;

endpackage

// ----- src/delta_list_sleep_queue_unit.sv -----
// ----------------------------------------------------------------------------
// delta_list_sleep_queue_unit
// Sleep queue kept as a delta list: adds threads in wake order, releases
// threads whose delay has run out on each timer tick.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  in      | in_valid/in_ready  | operation, thread_id, sleep_ticks
//  out     | out_valid/out_ready| woken_thread, woken_valid, last, add_status,
//          |                    | head_remaining
//
// items pass a two-entry input queue before the list engine
// add: accept, then walk the list one entry a cycle; the new entry is written in
// front of the first entry that wakes later, else appended at the end; no walk if full
// tick: decrement the head delta, release zero-delta threads, then emit the results
// a waiting result stalls the engine, the input queue keeps taking items until full
// reset empties the list and the queue at once
module delta_list_sleep_queue_unit import dlsq_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              operation,
	input  logic [TID_W-1:0]  thread_id,
	input  logic [TICK_W-1:0] sleep_ticks,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [TID_W-1:0]  woken_thread,
	output logic              woken_valid,
	output logic              last,
	output logic              add_status,
	output logic [TICK_W-1:0] head_remaining
);

	item_t item;
	logic  item_valid;
	logic  item_ready;

	dlsq_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.thread_id   (thread_id),
		.sleep_ticks (sleep_ticks),
		.item        (item),
		.item_valid  (item_valid),
		.item_ready  (item_ready)
	);

	dlsq_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.item           (item),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.woken_thread   (woken_thread),
		.woken_valid    (woken_valid),
		.last           (last),
		.add_status     (add_status),
		.head_remaining (head_remaining)
	);

endmodule

// ----- src/dlsq_front.sv -----
// ----------------------------------------------------------------------------
// dlsq_front
// Input side: takes items, decodes the operation and holds them in a
// two-entry queue in front of the list engine.
// ----------------------------------------------------------------------------
module dlsq_front import dlsq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              operation,
	input  logic [TID_W-1:0]  thread_id,
	input  logic [TICK_W-1:0] sleep_ticks,
	output item_t             item,
	output logic              item_valid,
	input  logic              item_ready
);

	item_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       pop;

	assign in_ready   = (cnt_q != 2'd2);
	assign item_valid = (cnt_q != 2'd0);
	assign item       = ent_q[rd_ptr_q];
	assign push       = in_valid && in_ready;
	assign pop        = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q].op    <= operation ? OPC_TICK : OPC_ADD;
			ent_q[wr_ptr_q].thr   <= thread_id;
			ent_q[wr_ptr_q].ticks <= sleep_ticks;
		end
	end

endmodule

// ----- src/dlsq_back.sv -----
// ----------------------------------------------------------------------------
// dlsq_back
// List engine: keeps the delta list as a shift line with slot 0 at the head,
// walks it one entry a cycle for inserts and releases woken threads on ticks.
// ----------------------------------------------------------------------------
module dlsq_back import dlsq_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  item_t             item,
	input  logic              item_valid,
	output logic              item_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [TID_W-1:0]  woken_thread,
	output logic              woken_valid,
	output logic              last,
	output logic              add_status,
	output logic [TICK_W-1:0] head_remaining
);

	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
	localparam int WCW  = $clog2(MAX_RESULTS + 1);
	localparam logic [CNTW-1:0] DEPTH_C = CNTW'(QUEUE_DEPTH);
	localparam logic [WCW-1:0]  MAXR_C  = WCW'(MAX_RESULTS);

	logic [TID_W-1:0]  ent_thr_q [QUEUE_DEPTH];
	logic [TICK_W-1:0] ent_dlt_q [QUEUE_DEPTH];
	logic [CNTW-1:0]   cnt_q;

	logic [TID_W-1:0]  buf_q [MAX_RESULTS];
	logic [WCW-1:0]    wc_q, wc_d;

	back_state_t       state_q, state_d;
	logic [CNTW-1:0]   rem_q, rem_d;
	logic [TICK_W-1:0] t_q, t_d;
	logic [TID_W-1:0]  job_thr_q, job_thr_d;
	logic              ins_q, ins_d;
	logic              adj_q, adj_d;
	logic              status_q, status_d;

	slot_op_t          slot_op;
	logic [TID_W-1:0]  w_thr;
	logic [TICK_W-1:0] w_dlt;
	logic              buf_wr;
	logic              buf_shift;
	logic              nonempty;
	logic [TICK_W-1:0] head_d;
	logic [TID_W-1:0]  head_thr;

	assign nonempty = (cnt_q != '0);
	assign head_d   = ent_dlt_q[0];
	assign head_thr = ent_thr_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			wc_q     <= '0;
			rem_q    <= '0;
			ins_q    <= 1'b0;
			adj_q    <= 1'b0;
			status_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			wc_q     <= wc_d;
			rem_q    <= rem_d;
			ins_q    <= ins_d;
			adj_q    <= adj_d;
			status_q <= status_d;
			case (slot_op)
				SOP_POP:  cnt_q <= cnt_q - CNTW'(1);
				SOP_PUSH: cnt_q <= cnt_q + CNTW'(1);
				default:  cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		t_q       <= t_d;
		job_thr_q <= job_thr_d;
	end

	always_comb begin
		state_d    = state_q;
		rem_d      = rem_q;
		t_d        = t_q;
		job_thr_d  = job_thr_q;
		ins_d      = ins_q;
		adj_d      = adj_q;
		status_d   = status_q;
		wc_d       = wc_q;
		slot_op    = SOP_NONE;
		w_thr      = job_thr_q;
		w_dlt      = t_q;
		buf_wr     = 1'b0;
		buf_shift  = 1'b0;
		item_ready = 1'b0;
		out_valid  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					wc_d     = '0;
					status_d = 1'b0;
					if (item.op == OPC_ADD) begin
						job_thr_d = item.thr;
						t_d       = item.ticks;
						ins_d     = 1'b0;
						adj_d     = 1'b0;
						rem_d     = cnt_q;
						if (cnt_q == DEPTH_C) begin
							status_d = 1'b1;
							state_d  = ST_EMIT;
						end else begin
							state_d = ST_WALK;
						end
					end else begin
						// saturating decrement of the head delta
						if (nonempty && head_d != '0) slot_op = SOP_DEC0;
						state_d = nonempty ? ST_REL : ST_EMIT;
					end
				end
			end
			ST_WALK: begin
				if (rem_q == '0) begin
					// every old entry seen; append if not placed yet
					if (!ins_q) slot_op = SOP_PUSH;
					state_d = ST_EMIT;
				end else if (!ins_q && head_d > t_q) begin
					// new entry goes before the head one, which is rotated next
					slot_op = SOP_PUSH;
					ins_d   = 1'b1;
					adj_d   = 1'b1;
				end else begin
					slot_op = SOP_ROT;
					w_thr   = head_thr;
					w_dlt   = adj_q ? (head_d - t_q) : head_d;
					adj_d   = 1'b0;
					if (!ins_q) t_d = t_q - head_d;
					rem_d   = rem_q - CNTW'(1);
				end
			end
			ST_REL: begin
				if (wc_q != MAXR_C && nonempty && head_d == '0) begin
					buf_wr  = 1'b1;
					wc_d    = wc_q + WCW'(1);
					slot_op = SOP_POP;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					buf_shift = 1'b1;
					if (wc_q > WCW'(1)) begin
						wc_d = wc_q - WCW'(1);
					end else begin
						wc_d    = '0;
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// list slots: pop and rotate shift toward the head, push writes the tail
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
		logic [TID_W-1:0]  up_thr;
		logic [TICK_W-1:0] up_dlt;
		if (i < QUEUE_DEPTH - 1) begin : g_up
			assign up_thr = ent_thr_q[i+1];
			assign up_dlt = ent_dlt_q[i+1];
		end else begin : g_end
			assign up_thr = ent_thr_q[i];
			assign up_dlt = ent_dlt_q[i];
		end
		always_ff @(posedge clk) begin
			case (slot_op)
				SOP_POP: begin
					ent_thr_q[i] <= up_thr;
					ent_dlt_q[i] <= up_dlt;
				end
				SOP_ROT: begin
					if (cnt_q == CNTW'(i + 1)) begin
						ent_thr_q[i] <= w_thr;
						ent_dlt_q[i] <= w_dlt;
					end else begin
						ent_thr_q[i] <= up_thr;
						ent_dlt_q[i] <= up_dlt;
					end
				end
				SOP_PUSH: begin
					if (cnt_q == CNTW'(i)) begin
						ent_thr_q[i] <= w_thr;
						ent_dlt_q[i] <= w_dlt;
					end
				end
				SOP_DEC0: begin
					if (i == 0) ent_dlt_q[i] <= ent_dlt_q[i] - TICK_W'(1);
				end
				default: ;
			endcase
		end
	end

	// woken thread line, emitted from slot 0
	for (genvar j = 0; j < MAX_RESULTS; j++) begin : g_buf
		logic [TID_W-1:0] up_b;
		if (j < MAX_RESULTS - 1) begin : g_up
			assign up_b = buf_q[j+1];
		end else begin : g_end
			assign up_b = buf_q[j];
		end
		always_ff @(posedge clk) begin
			if (buf_wr && wc_q == WCW'(j)) buf_q[j] <= head_thr;
			else if (buf_shift) buf_q[j] <= up_b;
		end
	end

	assign woken_valid    = (wc_q != '0);
	assign woken_thread   = woken_valid ? buf_q[0] : '0;
	assign last           = (wc_q <= WCW'(1));
	assign add_status     = status_q;
	assign head_remaining = nonempty ? head_d : '0;

endmodule

// ----- src/dlsq_checker.sv -----
// ----------------------------------------------------------------------------
// dlsq_checker
// Port-level checks of the sleep queue, bound to the top level.
// ----------------------------------------------------------------------------
module dlsq_checker import dlsq_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input logic [TID_W-1:0]  woken_thread,
	input logic              woken_valid,
	input logic              last,
	input logic              add_status
);

	// a result waiting for transfer stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before transfer");

	// a result without a woken thread is always the only one of its item
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !woken_valid |-> last)
		else $error("empty result not marked last");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !woken_valid |-> woken_thread == '0)
		else $error("thread id shown without a woken thread");

	// a dropped add never releases anything
	a_full_add: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && add_status |-> !woken_valid && last)
		else $error("full status on a tick result");

endmodule

bind delta_list_sleep_queue_unit dlsq_checker u_dlsq_checker (.*);
